@@ rtl/core/gasm_pkg.sv @@
// gasm_pkg: shared types and constants for the gained audio source mixer
// no dependencies; imported by every module under rtl/core
`default_nettype none

package gasm_pkg;

	localparam int MAX_SOURCES = 4;
	localparam int SAMPLE_W    = 16;
	localparam int GAIN_W      = 15;
	localparam int LEN_W       = 24;
	localparam int COUNT_W     = 25;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int PROD_W      = SAMPLE_W + GAIN_W;   // signed sample times unsigned gain
	localparam int TERM_W      = PROD_W - 8;          // product over 256
	localparam int SUM_W       = TERM_W + 2;          // room for four terms

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic signed [SUM_W-1:0]    MIX_MAX = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0]    MIX_MIN = SUM_W'(-32768);
	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

	// register map of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_A   = 3'd0,
		REG_GAIN_B   = 3'd1,
		REG_GAIN_C   = 3'd2,
		REG_GAIN_D   = 3'd3,
		REG_LENGTH_A = 3'd4,
		REG_LENGTH_B = 3'd5,
		REG_LENGTH_C = 3'd6,
		REG_LENGTH_D = 3'd7
	} cfg_reg_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [GAIN_W-1:0]   gain_t;
	typedef logic        [LEN_W-1:0]    length_t;
	typedef logic signed [TERM_W-1:0]   term_t;

	// result of the sum and saturate step
	typedef struct packed {
		sample_t mixed;
		logic    clipped;
	} mix_result_t;

endpackage

`default_nettype wire

@@ rtl/core/gained_audio_source_mixer.sv @@
// gained_audio_source_mixer: top level of the four-source Q8 gain mixer
// depends on gasm_pkg, gasm_cfg_regs, gasm_term, gasm_sum_sat
//
// usage
//  - input channel (in_valid/in_ready): one transaction per interleaved stereo
//    sample position, one sample per source plus the first flag, which
//    restarts the 25-bit position counter at zero for that transaction
//  - output channel (out_valid/out_ready): one transaction per input, carrying
//    the saturated mix and a clip flag, in input order
//  - config port: cfg_write with cfg_index selects gain_a..d (0..3) or
//    length_a..d (4..7); gains take cfg_data[14:0]; write only while idle
//  - a source is heard while position/2 is below its length; length zero
//    silences it, sources at or beyond NUM_SOURCES are ignored
//  - two register stages: input register, then output register; the
//    multipliers, adder and saturation sit between them
//  - throughput one transaction per cycle while out_ready is high, set by
//    one multiplier per source and the four-way adder in the single stage
//    between the two registers
//  - receiver stall: the stages fill up and in_ready falls once both hold
//    data; a held result stays stable until taken
//  - reset clears the counter, config registers and stage valid flags only
`default_nettype none

module gained_audio_source_mixer #(
	parameter int NUM_SOURCES = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_write,
	input  wire logic [gasm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gasm_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            first,
	input  gasm_pkg::sample_t                    sample_a,
	input  gasm_pkg::sample_t                    sample_b,
	input  gasm_pkg::sample_t                    sample_c,
	input  gasm_pkg::sample_t                    sample_d,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output gasm_pkg::sample_t                    mixed,
	output logic                                 clipped
);
	import gasm_pkg::*;

	// configuration registers
	gain_t   gain   [NUM_SOURCES];
	length_t length [NUM_SOURCES];

	gasm_cfg_regs #(
		.NUM_SOURCES (NUM_SOURCES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.gain      (gain),
		.length    (length)
	);

	// pipeline handshake: each stage moves when the next one has room
	logic valid_s1, out_valid_q;
	logic in_fire, load_out;

	assign load_out = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || load_out;
	assign in_fire  = in_valid && in_ready;

	// position counter, restart on first, saturating at the top
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] pos;
	logic [LEN_W-1:0]   frame;

	assign pos   = first ? '0 : count_q;
	assign frame = pos[COUNT_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire) begin
			count_q <= (pos == COUNT_MAX) ? pos : pos + COUNT_W'(1);
		end
	end

	// gather the sample ports into source order
	sample_t sample_in [MAX_SOURCES];

	assign sample_in[0] = sample_a;
	assign sample_in[1] = sample_b;
	assign sample_in[2] = sample_c;
	assign sample_in[3] = sample_d;

	// stage 1: input register with per-source activity resolved at accept
	sample_t                sample_s1 [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] active_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				sample_s1[i] <= sample_in[i];
				// frame below length also rules out a zero length
				active_s1[i] <= (frame < length[i]);
			end
		end
	end

	// gained terms, one multiplier per source
	term_t term_c [NUM_SOURCES];

	for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_term
		gasm_term u_term (
			.sample (sample_s1[i]),
			.gain   (gain[i]),
			.active (active_s1[i]),
			.term   (term_c[i])
		);
	end

	// output register: sum and saturate
	mix_result_t result_c;
	mix_result_t result_q;

	gasm_sum_sat #(
		.NUM_SOURCES (NUM_SOURCES)
	) u_sum (
		.term   (term_c),
		.result (result_c)
	);

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= result_c;
		end
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (load_out) begin
				valid_s1 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign mixed     = result_q.mixed;
	assign clipped   = result_q.clipped;

	// full pipeline with a stalled receiver takes nothing new
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while every stage is blocked");

	// a restart leaves the counter at one
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && first) |=> (count_q == COUNT_W'(1)))
		else $error("counter did not restart on first");

	// counter holds at its top value
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !first && count_q == COUNT_MAX) |=> (count_q == COUNT_MAX))
		else $error("counter wrapped past its maximum");

	// a clipped result sits on a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |-> (mixed == OUT_MAX || mixed == OUT_MIN))
		else $error("clip flag without a saturated value");

	// a held result keeps its value until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result_q)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

@@ rtl/core/gasm_cfg_regs.sv @@
// gasm_cfg_regs: per-source gain and length registers behind the write port
// depends on gasm_pkg
`default_nettype none

module gasm_cfg_regs #(
	parameter int NUM_SOURCES = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [gasm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gasm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output gasm_pkg::gain_t                         gain   [NUM_SOURCES],
	output gasm_pkg::length_t                       length [NUM_SOURCES]
);
	import gasm_pkg::*;

	gain_t   gain_q   [NUM_SOURCES];
	length_t length_q [NUM_SOURCES];

	for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_src
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				gain_q[i]   <= '0;
				length_q[i] <= '0;
			end else if (cfg_write) begin
				if (cfg_index == CFG_IDX_W'(REG_GAIN_A) + CFG_IDX_W'(i)) begin
					gain_q[i] <= cfg_data[GAIN_W-1:0];
				end
				if (cfg_index == CFG_IDX_W'(REG_LENGTH_A) + CFG_IDX_W'(i)) begin
					length_q[i] <= cfg_data[LEN_W-1:0];
				end
			end
		end

		assign gain[i]   = gain_q[i];
		assign length[i] = length_q[i];
	end

endmodule

`default_nettype wire

@@ rtl/core/gasm_term.sv @@
// gasm_term: one source's gained contribution, sample times Q8 gain over 256
// rounded toward zero; depends on gasm_pkg
`default_nettype none

module gasm_term (
	input  gasm_pkg::sample_t sample,
	input  gasm_pkg::gain_t   gain,
	input  wire logic         active,
	output gasm_pkg::term_t   term
);
	import gasm_pkg::*;

	logic signed [PROD_W-1:0] prod;
	term_t                    floor_q8;
	logic                     round_up;

	always_comb begin
		prod     = PROD_W'(sample) * PROD_W'($signed({1'b0, gain}));
		floor_q8 = prod[PROD_W-1:8];
		// negative with a fraction: step back toward zero
		round_up = prod[PROD_W-1] & (|prod[7:0]);
		if (!active) begin
			term = '0;
		end else if (round_up) begin
			term = floor_q8 + TERM_W'(1);
		end else begin
			term = floor_q8;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/gasm_sum_sat.sv @@
// gasm_sum_sat: adds the source terms and saturates to signed 16 bits
// depends on gasm_pkg
`default_nettype none

module gasm_sum_sat #(
	parameter int NUM_SOURCES = 4
) (
	input  gasm_pkg::term_t       term [NUM_SOURCES],
	output gasm_pkg::mix_result_t result
);
	import gasm_pkg::*;

	logic signed [SUM_W-1:0] sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			sum = sum + SUM_W'(term[i]);
		end
		priority if (sum > MIX_MAX) begin
			result.mixed   = OUT_MAX;
			result.clipped = 1'b1;
		end else if (sum < MIX_MIN) begin
			result.mixed   = OUT_MIN;
			result.clipped = 1'b1;
		end else begin
			result.mixed   = sum[SAMPLE_W-1:0];
			result.clipped = 1'b0;
		end
	end

endmodule

`default_nettype wire
